// ===== src/sufc_pkg.sv =====
// ----------------------------------------------------------------------------
// sufc_pkg: shared definitions for the stereo upmix FIR clip core
// Sizes, register indexes, microcode step codes, control and status structs,
// and the center channel coefficient table.
// ----------------------------------------------------------------------------
package sufc_pkg;

    // Core sizes
    localparam int TAP_COUNT    = 128;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 18;

    // Gain and surround scaling
    localparam int GAIN_W      = 20;
    localparam int GAIN_SHIFT  = 16;
    localparam int SURR_COEF   = 92572;
    localparam int SURR_W      = 18;
    localparam int SURR_SHIFT  = 16;
    localparam int CLIP_W      = SAMPLE_WIDTH - 1;

    // Derived datapath widths
    localparam int TAP_IDX_W = $clog2(TAP_COUNT);
    localparam int HIST_W    = SAMPLE_WIDTH + 1;
    localparam int MULB_A    = (GAIN_W + 1 > SURR_W) ? GAIN_W + 1 : SURR_W;
    localparam int MULB_W    = (MULB_A > COEF_WIDTH) ? MULB_A : COEF_WIDTH;
    localparam int P_W       = HIST_W + MULB_W;
    localparam int ACC_W     = HIST_W + COEF_WIDTH + TAP_IDX_W + 1;
    localparam int SAT_W     = ((ACC_W > P_W) ? ACC_W : P_W) + 2;

    // Stream payload widths, padded to whole bytes
    localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((6 * SAMPLE_WIDTH + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (GAIN_W > CLIP_W) ? GAIN_W : CLIP_W;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLIP   = CFG_IDX_W'(2);
    localparam logic [GAIN_W-1:0]    GAIN_RESET = GAIN_W'(65536);
    localparam logic [CLIP_W-1:0]    CLIP_RESET = CLIP_W'(4194304);

    // Microcode step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE    = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_GAIN_L  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_GAIN_R  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_SURR_L  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_SURR_R  = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_HIST_WR = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_FIR     = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_DRAIN1  = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_DRAIN2  = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_FINISH  = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_PASS    = STEP_W'(10);

    // Multiplier operand select for the scalar steps
    typedef enum logic [1:0] {
        MUL_L_GAIN,
        MUL_R_GAIN,
        MUL_GL_SURR,
        MUL_GR_SURR
    } mul_sel_t;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_DISABLED,
        JC_TAP_MORE
    } jcond_t;

    // One microcode control word
    typedef struct packed {
        logic              in_ready;
        mul_sel_t          mul_sel;
        logic              ld_gl;
        logic              ld_gr;
        logic              ld_sl;
        logic              ld_sr;
        logic              ld_sum;
        logic              ram_wr;
        logic              acc_clr;
        logic              tap_clr;
        logic              rd_issue;
        logic              hold_out;
        logic              out_full;
        logic              out_pass;
        logic              ptr_inc;
        jcond_t            jcond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic enable;
        logic tap_last;
        logic out_busy;
    } status_t;

    // Configuration register set
    typedef struct packed {
        logic              enable;
        logic [GAIN_W-1:0] gain;
        logic [CLIP_W-1:0] clip;
    } cfg_t;

    // Center FIR coefficients, Q0.17
    localparam int ROM_TAPS  = 128;
    localparam int ROM_FRAC  = 17;
    localparam int ROM_IDX_W = $clog2(ROM_TAPS);
    localparam int COEF_LSH  = (COEF_WIDTH - 1 >= ROM_FRAC) ? COEF_WIDTH - 1 - ROM_FRAC : 0;
    localparam int COEF_RSH  = (COEF_WIDTH - 1 >= ROM_FRAC) ? 0 : ROM_FRAC - (COEF_WIDTH - 1);

    localparam int COEF_ROM [ROM_TAPS] = '{
        -231, -234, -238, -241, -245, -248, -252, -255, -258, -262,
        -265, -268, -271, -274, -277, -281, -284, -287, -290, -292,
        -295, -298, -301, -304, -306, -309, -311, -314, -316, -319,
        -321, -323, -326, -328, -330, -332, -334, -336, -338, -340,
        -341, -343, -345, -346, -348, -349, -350, -352, -353, -354,
        -355, -356, -357, -358, -358, -359, -360, -360, -360, -361,
        -361, -361, -361,
        130709,
        -361, -361, -361,
        -361, -360, -360, -360, -359, -358, -358, -357, -356, -355,
        -354, -353, -352, -350, -349, -348, -346, -345, -343, -341,
        -340, -338, -336, -334, -332, -330, -328, -326, -323, -321,
        -319, -316, -314, -311, -309, -306, -304, -301, -298, -295,
        -292, -290, -287, -284, -281, -277, -274, -271, -268, -265,
        -262, -258, -255, -252, -248, -245, -241, -238, -234, -231,
        -227
    };

    // Coefficient for tap j, rescaled to COEF_WIDTH bits; taps past the table are zero
    function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_IDX_W-1:0] j);
        logic signed [47:0] c;
        logic signed [47:0] r;
        c = 48'(COEF_ROM[ROM_IDX_W'(j)]);
        if (int'(j) >= ROM_TAPS) begin
            r = '0;
        end
        else if (COEF_RSH == 0) begin
            r = c <<< COEF_LSH;
        end
        else begin
            r = (c + (48'sd1 <<< (COEF_RSH - 1))) >>> COEF_RSH;
        end
        return COEF_WIDTH'(r);
    endfunction

endpackage

// ===== src/sufc_ram.sv =====
// ----------------------------------------------------------------------------
// sufc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/sufc_seq.sv =====
// ----------------------------------------------------------------------------
// sufc_seq: microcode sequencer
// Step counter over a read-only control program with conditional jumps; a
// step that loads the output register holds while the output is still full.
// ----------------------------------------------------------------------------
module sufc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  sufc_pkg::status_t sts,
    output sufc_pkg::ctrl_t   ctrl
);

    import sufc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             word;
    logic              stall;
    logic              take;

    // Control program
    function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.in_ready = 1'b1;
                w.jcond    = JC_NO_INPUT;
                w.target   = STEP_IDLE;
            end
            STEP_GAIN_L:
            begin
                w.mul_sel = MUL_L_GAIN;
                w.jcond   = JC_DISABLED;
                w.target  = STEP_PASS;
            end
            STEP_GAIN_R:
            begin
                w.mul_sel = MUL_R_GAIN;
                w.ld_gl   = 1'b1;
            end
            STEP_SURR_L:
            begin
                w.mul_sel = MUL_GL_SURR;
                w.ld_gr   = 1'b1;
            end
            STEP_SURR_R:
            begin
                w.mul_sel = MUL_GR_SURR;
                w.ld_sl   = 1'b1;
                w.ld_sum  = 1'b1;
            end
            STEP_HIST_WR:
            begin
                w.ld_sr   = 1'b1;
                w.ram_wr  = 1'b1;
                w.acc_clr = 1'b1;
                w.tap_clr = 1'b1;
            end
            STEP_FIR:
            begin
                w.rd_issue = 1'b1;
                w.jcond    = JC_TAP_MORE;
                w.target   = STEP_FIR;
            end
            STEP_DRAIN1, STEP_DRAIN2:
            begin
                w.jcond = JC_NONE;
            end
            STEP_FINISH:
            begin
                w.hold_out = 1'b1;
                w.out_full = 1'b1;
                w.ptr_inc  = 1'b1;
                w.jcond    = JC_ALWAYS;
                w.target   = STEP_IDLE;
            end
            STEP_PASS:
            begin
                w.hold_out = 1'b1;
                w.out_pass = 1'b1;
                w.jcond    = JC_ALWAYS;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.jcond  = JC_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // Fetch, stall and jump decision
    always_comb
    begin
        word  = ucode_word(step_reg);
        stall = word.hold_out && sts.out_busy;
        unique case (word.jcond)
            JC_NONE:     take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_NO_INPUT: take = !sts.in_valid;
            JC_DISABLED: take = !sts.enable;
            JC_TAP_MORE: take = !sts.tap_last;
            default:     take = 1'b0;
        endcase
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
        ctrl = stall ? ctrl_t'('0) : word;
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Input is taken only at the idle step
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.in_ready |-> step_reg == STEP_IDLE)
        else $error("input ready outside idle step");

    // A stalled step holds its place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(step_reg))
        else $error("step advanced during output stall");

    // Program counter never leaves the program
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_PASS)
        else $error("step counter outside the program");

endmodule

// ===== src/sufc_datapath.sv =====
// ----------------------------------------------------------------------------
// sufc_datapath: shared multiplier datapath
// Gain, surround and FIR products through one registered multiplier, tap
// history RAM with valid bits, accumulator and the output register.
// ----------------------------------------------------------------------------
module sufc_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  sufc_pkg::cfg_t                           cfg,
    input  sufc_pkg::ctrl_t                          ctrl,
    output sufc_pkg::status_t                        sts,
    input  logic                                     in_valid,
    input  logic signed [sufc_pkg::SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [sufc_pkg::SAMPLE_WIDTH-1:0] right_sample,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic [sufc_pkg::OUT_W-1:0]               out_data
);

    import sufc_pkg::*;

    localparam int AEXT_W = TAP_IDX_W + 1;
    localparam logic signed [SAT_W-1:0] SAT_MAX   = (SAT_W'(1) <<< (SAMPLE_WIDTH - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] SAT_MIN   = -SAT_MAX - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] GAIN_HALF = SAT_W'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [SAT_W-1:0] SURR_HALF = SAT_W'(1) <<< (SURR_SHIFT - 1);
    localparam logic signed [SAT_W-1:0] CTR_HALF  = SAT_W'(1) <<< (COEF_WIDTH - 2);

    // Registers
    logic signed [SAMPLE_WIDTH-1:0] l_reg;
    logic signed [SAMPLE_WIDTH-1:0] r_reg;
    logic signed [P_W-1:0]          p_reg;
    logic signed [SAMPLE_WIDTH-1:0] gl_reg;
    logic signed [SAMPLE_WIDTH-1:0] gr_reg;
    logic signed [SAMPLE_WIDTH-1:0] sl_reg;
    logic signed [SAMPLE_WIDTH-1:0] sr_reg;
    logic signed [HIST_W-1:0]       sum_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [TAP_IDX_W-1:0]           tap_reg;
    logic [TAP_IDX_W-1:0]           tap_d1_reg;
    logic [TAP_IDX_W-1:0]           ptr_reg;
    logic [TAP_COUNT-1:0]           hist_valid_reg;
    logic                           valid_rd_reg;
    logic                           rd_pend_reg;
    logic                           mul_pend_reg;
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_data_reg;

    // Combinational nets
    logic signed [HIST_W-1:0]       mul_a;
    logic signed [MULB_W-1:0]       mul_b;
    logic signed [P_W-1:0]          p_next;
    logic signed [HIST_W-1:0]       hist_tap;
    logic [HIST_W-1:0]              rd_data;
    logic [AEXT_W-1:0]              addr_ext;
    logic [TAP_IDX_W-1:0]           rd_addr;
    logic signed [SAT_W-1:0]        p_ext;
    logic signed [SAT_W-1:0]        g_rnd;
    logic signed [SAT_W-1:0]        s_rnd;
    logic signed [SAT_W-1:0]        c_rnd;
    logic signed [SAMPLE_WIDTH-1:0] g_sat;
    logic signed [SAMPLE_WIDTH-1:0] s_sat;
    logic signed [SAMPLE_WIDTH-1:0] center;
    logic signed [HIST_W-1:0]       clip_s;
    logic signed [HIST_W-1:0]       lfe_w;
    logic                           in_fire;
    logic                           out_load;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    assign in_fire  = ctrl.in_ready && in_valid;
    assign out_load = ctrl.out_full || ctrl.out_pass;

    // Status back to the sequencer
    assign sts.in_valid = in_valid;
    assign sts.enable   = cfg.enable;
    assign sts.tap_last = (tap_reg == TAP_IDX_W'(TAP_COUNT - 1));
    assign sts.out_busy = out_valid_reg && !out_ready;

    // History read address: newest sample minus tap, modulo the depth
    always_comb
    begin
        addr_ext = AEXT_W'(ptr_reg) + (AEXT_W'(TAP_COUNT) - AEXT_W'(tap_reg));
        if (addr_ext >= AEXT_W'(TAP_COUNT))
        begin
            addr_ext = addr_ext - AEXT_W'(TAP_COUNT);
        end
        rd_addr = addr_ext[TAP_IDX_W-1:0];
    end

    sufc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (TAP_COUNT)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (ctrl.ram_wr),
        .wr_addr (ptr_reg),
        .wr_data (sum_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Slots never written since reset read as zero
    assign hist_tap = valid_rd_reg ? signed'(rd_data) : '0;

    // Select multiplier operands; a pending history read takes priority
    always_comb
    begin
        mul_a = HIST_W'(l_reg);
        mul_b = MULB_W'({1'b0, cfg.gain});
        if (rd_pend_reg)
        begin
            mul_a = hist_tap;
            mul_b = MULB_W'(coef_at(tap_d1_reg));
        end
        else
        begin
            unique case (ctrl.mul_sel)
                MUL_L_GAIN:
                begin
                    mul_a = HIST_W'(l_reg);
                    mul_b = MULB_W'({1'b0, cfg.gain});
                end
                MUL_R_GAIN:
                begin
                    mul_a = HIST_W'(r_reg);
                    mul_b = MULB_W'({1'b0, cfg.gain});
                end
                MUL_GL_SURR:
                begin
                    mul_a = HIST_W'(gl_reg);
                    mul_b = MULB_W'(SURR_COEF);
                end
                MUL_GR_SURR:
                begin
                    mul_a = HIST_W'(gr_reg);
                    mul_b = MULB_W'(SURR_COEF);
                end
                default:
                begin
                    mul_a = HIST_W'(l_reg);
                    mul_b = MULB_W'({1'b0, cfg.gain});
                end
            endcase
        end
        p_next = P_W'(mul_a) * P_W'(mul_b);
    end

    // Round and saturate the registered product and the accumulator
    always_comb
    begin
        p_ext  = SAT_W'(p_reg);
        g_rnd  = (p_ext + GAIN_HALF) >>> GAIN_SHIFT;
        s_rnd  = -((p_ext + SURR_HALF) >>> SURR_SHIFT);
        c_rnd  = (SAT_W'(acc_reg) + CTR_HALF) >>> (COEF_WIDTH - 1);
        g_sat  = sat_sample(g_rnd);
        s_sat  = sat_sample(s_rnd);
        center = sat_sample(c_rnd);
    end

    // LFE: symmetric clip of the sum
    always_comb
    begin
        clip_s = HIST_W'(cfg.clip);
        if (sum_reg > clip_s)
        begin
            lfe_w = clip_s;
        end
        else if (sum_reg < -clip_s)
        begin
            lfe_w = -clip_s;
        end
        else
        begin
            lfe_w = sum_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        tap_d1_reg <= tap_reg;
        if (in_fire)
        begin
            l_reg <= left_sample;
            r_reg <= right_sample;
        end
        if (ctrl.ld_gl)
        begin
            gl_reg <= g_sat;
        end
        if (ctrl.ld_gr)
        begin
            gr_reg <= g_sat;
        end
        if (ctrl.ld_sl)
        begin
            sl_reg <= s_sat;
        end
        if (ctrl.ld_sr)
        begin
            sr_reg <= s_sat;
        end
        if (ctrl.ld_sum)
        begin
            sum_reg <= HIST_W'(gl_reg) + HIST_W'(gr_reg);
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_pend_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(p_reg);
        end
        if (ctrl.out_full)
        begin
            out_data_reg <= OUT_W'({lfe_w[SAMPLE_WIDTH-1:0], sr_reg, sl_reg,
                                    center, gr_reg, gl_reg});
        end
        else if (ctrl.out_pass)
        begin
            out_data_reg <= OUT_W'({r_reg, l_reg});
        end
    end

    // Control registers: tap and pointer counters, valid bits, pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg        <= '0;
            ptr_reg        <= '0;
            hist_valid_reg <= '0;
            valid_rd_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            mul_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_rd_reg <= hist_valid_reg[rd_addr];
            rd_pend_reg  <= ctrl.rd_issue;
            mul_pend_reg <= rd_pend_reg;
            if (ctrl.tap_clr)
            begin
                tap_reg <= '0;
            end
            else if (ctrl.rd_issue)
            begin
                tap_reg <= tap_reg + TAP_IDX_W'(1);
            end
            if (ctrl.ram_wr)
            begin
                hist_valid_reg[ptr_reg] <= 1'b1;
            end
            if (ctrl.ptr_inc)
            begin
                ptr_reg <= (ptr_reg == TAP_IDX_W'(TAP_COUNT - 1)) ? '0
                           : ptr_reg + TAP_IDX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // History write never overlaps an in-flight tap read
    a_wr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ram_wr |-> !rd_pend_reg && !mul_pend_reg)
        else $error("history write during FIR read");

    // Tap pipeline has drained before the center result is taken
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_full |-> !rd_pend_reg && !mul_pend_reg && !ctrl.rd_issue)
        else $error("result loaded before accumulator drained");

    // A loaded result is presented on the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("output load lost");

endmodule

// ===== src/stereo_upmix_fir_clip_core.sv =====
// ----------------------------------------------------------------------------
// stereo_upmix_fir_clip_core: stereo to 5.1 upmix with center FIR and LFE clip
// Top level: configuration registers, stream ports, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one stereo pair per transfer, master stream m_*
//   one six-channel result per transfer. Configuration writes go through
//   cfg_valid/cfg_ready (always ready) with cfg_index 0 = enable,
//   1 = gain_linear, 2 = clip_level; other indexes are ignored. Write
//   configuration only while no pair is in flight.
//   Enabled: one shared multiplier does gain, surround and 128 FIR taps in
//   turn, so a pair runs through these steps between one input transfer
//   and the next (the result turns valid as s_tready comes back): idle
//   step, five scalar steps, 128 tap steps, two pipeline drain steps and
//   a finish step.
//   Disabled: pass-through, history untouched.
//   Reset clears the configuration to its defaults, the history pointer and
//   the history valid bits (unwritten history reads as zero); no clearing
//   pass is needed. The result sits in an output register; when m_tready is
//   low a new pair is still accepted and processed, and the finish step
//   holds until the previous result has been transferred.
// ----------------------------------------------------------------------------
module stereo_upmix_fir_clip_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream: [23:0] left_sample, [47:24] right_sample
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sufc_pkg::IN_W-1:0]          s_tdata,
    // Output stream: [23:0] front_left, [47:24] front_right, [71:48] center_out,
    // [95:72] surround_left, [119:96] surround_right, [143:120] lfe_out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sufc_pkg::OUT_W-1:0]         m_tdata,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sufc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sufc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import sufc_pkg::*;

    logic              enable_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [CLIP_W-1:0] clip_reg;
    cfg_t              cfg;
    ctrl_t             ctrl;
    status_t           sts;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gain_reg   <= GAIN_RESET;
            clip_reg   <= CLIP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_CLIP:   clip_reg   <= cfg_data[CLIP_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg.enable = enable_reg;
    assign cfg.gain   = gain_reg;
    assign cfg.clip   = clip_reg;

    sufc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctrl  (ctrl)
    );

    sufc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ctrl         (ctrl),
        .sts          (sts),
        .in_valid     (s_tvalid),
        .left_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .right_sample (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_data     (m_tdata)
    );

    assign s_tready = ctrl.in_ready;

endmodule
